// File: hdl/afk_pkg.sv
// package: types and constants of the arm kinematics block
package afk_pkg;
   localparam int ANGLE_BITS_DEF = 16;
   localparam int COORD_BITS_DEF = 24;
   localparam int LINK_BITS = 21;
   localparam int CSR_DATA_BITS = 63;
   localparam int CSR_ADDR_BITS = 3;
   localparam int NUM_JOINTS = 6;
   localparam int SUM_BITS = 28;
   localparam int VEC_BITS = 23;

   typedef enum logic [1:0] {
      AXIS_X = 2'd0,
      AXIS_Y = 2'd1,
      AXIS_Z = 2'd2
   } axis_type;
endpackage

// File: hdl/afk_if.sv
// valid/ready channel interface carrying one payload word
interface afk_if #(parameter type payload_type = logic) (input logic clock);
   logic valid;
   logic ready;
   payload_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

// File: hdl/afk_front.sv
// front end: takes angle words and turns them into sine/cosine jobs in a queue
module afk_front #(
   parameter int ANGLE_BITS = afk_pkg::ANGLE_BITS_DEF
) (
   input  logic clock,
   input  logic reset,
   input  logic in_valid,
   output logic in_ready,
   input  logic [6*ANGLE_BITS-1:0] in_angles,
   output logic q_valid,
   input  logic q_ready,
   output logic [6*36-1:0] q_trig
);
   import afk_pkg::*;
   localparam int QW = 6*36;
   localparam int LANES = 12;

   typedef enum logic [1:0] {
      PH_SQUARE = 2'd0,
      PH_INNER = 2'd1,
      PH_OUTER = 2'd2,
      PH_FINAL = 2'd3
   } phase_type;

   logic [QW-1:0] q_ff [2];
   logic [1:0] cnt_ff, cnt_in;
   logic wr_ff, wr_in, rd_ff, rd_in;
   logic [QW-1:0] stage_ff, stage_in;
   logic stage_v_ff, stage_v_in;
   logic calc_v_ff, calc_v_in;
   phase_type ph_ff, ph_in;
   logic [15:0] x_ff [LANES];
   logic [15:0] x2_ff [LANES];
   logic [15:0] t_ff [LANES];
   logic [LANES-1:0] neg_ff;
   logic [15:0] x_in [LANES];
   logic [15:0] x2_in [LANES];
   logic [15:0] t_in [LANES];
   logic [LANES-1:0] neg_in;
   logic [15:0] arg [LANES];
   logic push, pop, take, fin;

   // even lanes sine, odd lanes cosine
   always_comb begin
      for (int j = 0; j < 6; j++) begin
         arg[2*j] = 16'((24'(in_angles[j*ANGLE_BITS +: ANGLE_BITS]) << (24-ANGLE_BITS)) >> 8);
         arg[2*j+1] = arg[2*j] + 16'd16384;
      end
   end

   // quarter-wave polynomial, one multiply per lane per cycle
   always_comb begin
      for (int l = 0; l < LANES; l++) begin
         logic [14:0] f;
         logic [15:0] op_a, op_b;
         logic [31:0] p;
         logic [16:0] r;
         logic signed [17:0] m;
         f = {1'b0, arg[l][13:0]};
         x_in[l] = x_ff[l];
         x2_in[l] = x2_ff[l];
         t_in[l] = t_ff[l];
         neg_in[l] = neg_ff[l];
         case (ph_ff)
            PH_SQUARE: begin
               op_a = x_ff[l];
               op_b = x_ff[l];
            end
            PH_INNER: begin
               op_a = x2_ff[l];
               op_b = 16'd2320;
            end
            PH_OUTER: begin
               op_a = x2_ff[l];
               op_b = t_ff[l];
            end
            default: begin
               op_a = x_ff[l];
               op_b = t_ff[l];
            end
         endcase
         p = 32'(op_a) * 32'(op_b);
         r = p[31:15];
         m = (r > 17'd32767) ? 18'sd32767 : $signed({1'b0, r});
         stage_in[l*18 +: 18] = neg_ff[l] ? -m : m;
         if (calc_v_ff) begin
            case (ph_ff)
               PH_SQUARE: x2_in[l] = p[30:15];
               PH_INNER: t_in[l] = 16'd21024 - p[30:15];
               PH_OUTER: t_in[l] = 16'd51472 - p[30:15];
               default: ;
            endcase
         end
         if (take) begin
            x_in[l] = {arg[l][14] ? 15'd16384 - f : f, 1'b0};
            neg_in[l] = arg[l][15];
         end
      end
   end

   always_comb begin
      ph_in = ph_ff;
      if (take) ph_in = PH_SQUARE;
      else if (calc_v_ff) begin
         case (ph_ff)
            PH_SQUARE: ph_in = PH_INNER;
            PH_INNER: ph_in = PH_OUTER;
            default: ph_in = PH_FINAL;
         endcase
      end
   end

   // trig unit, one stage, then a two-deep queue
   assign fin = calc_v_ff && (ph_ff == PH_FINAL) && (!stage_v_ff || push);
   assign in_ready = !calc_v_ff || fin;
   assign take = in_valid && in_ready;
   assign calc_v_in = take || (calc_v_ff && !fin);
   assign push = stage_v_ff && (cnt_ff != 2'd2);
   assign pop = q_valid && q_ready;
   assign stage_v_in = fin || (stage_v_ff && !push);
   assign cnt_in = cnt_ff + 2'(push) - 2'(pop);
   assign wr_in = wr_ff ^ push;
   assign rd_in = rd_ff ^ pop;
   assign q_valid = cnt_ff != 2'd0;
   assign q_trig = q_ff[rd_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
         wr_ff <= 1'b0;
         rd_ff <= 1'b0;
         stage_v_ff <= 1'b0;
         calc_v_ff <= 1'b0;
         ph_ff <= PH_SQUARE;
      end else begin
         cnt_ff <= cnt_in;
         wr_ff <= wr_in;
         rd_ff <= rd_in;
         stage_v_ff <= stage_v_in;
         calc_v_ff <= calc_v_in;
         ph_ff <= ph_in;
      end
      for (int l = 0; l < LANES; l++) begin
         x_ff[l] <= x_in[l];
         x2_ff[l] <= x2_in[l];
         t_ff[l] <= t_in[l];
      end
      neg_ff <= neg_in;
      if (fin) stage_ff <= stage_in;
      if (push) q_ff[wr_ff] <= stage_ff;
   end

`ifndef SYNTHESIS
   a_cnt: assert property (@(posedge clock) disable iff (reset) cnt_ff <= 2'd2)
      else $error("queue count overflow");
   a_pop: assert property (@(posedge clock) disable iff (reset) pop |-> cnt_ff != 2'd0)
      else $error("pop from empty queue");
   a_full: assert property (@(posedge clock) disable iff (reset)
      (cnt_ff == 2'd2 && !pop) |=> cnt_ff == 2'd2)
      else $error("full queue lost a word");
`endif
endmodule

// File: hdl/afk_back.sv
// back end: one rotation/cycle unless out stalls; sums, emits 6 positions/job
module afk_back #(
   parameter int COORD_BITS = afk_pkg::COORD_BITS_DEF
) (
   input  logic clock,
   input  logic reset,
   input  logic q_valid,
   output logic q_ready,
   input  logic [6*36-1:0] q_trig,
   input  logic [6*63-1:0] links,
   output logic out_valid,
   input  logic out_ready,
   output logic [2:0] out_joint,
   output logic signed [COORD_BITS-1:0] out_x,
   output logic signed [COORD_BITS-1:0] out_y,
   output logic signed [COORD_BITS-1:0] out_z,
   output logic out_last
);
   import afk_pkg::*;
   // rot step k walks j from k down to base; busy holds job
   logic busy_ff, busy_in;
   logic [6*36-1:0] trig_ff;
   logic [2:0] k_ff, k_in, j_ff, j_in;
   logic signed [VEC_BITS-1:0] vx_ff, vy_ff, vz_ff, vx_in, vy_in, vz_in;
   logic signed [SUM_BITS-1:0] px_ff, py_ff, pz_ff, px_in, py_in, pz_in;
   logic ov_ff, ov_in;
   logic [2:0] oj_ff, oj_in;
   logic signed [COORD_BITS-1:0] ox_ff, oy_ff, oz_ff, ox_in, oy_in, oz_in;
   logic signed [17:0] s, c;
   axis_type axis;
   logic signed [VEC_BITS-1:0] rx, ry, rz;
   logic [2:0] base;
   logic step_done, emit, take;
   logic signed [SUM_BITS-1:0] sx, sy, sz;

   function automatic logic signed [VEC_BITS-1:0] rnd(input logic signed [42:0] v);
      logic signed [42:0] t;
      t = (v + 43'sd16384) >>> 15;
      return VEC_BITS'(t);
   endfunction

   function automatic logic signed [COORD_BITS-1:0] sat(input logic signed [SUM_BITS-1:0] v);
      logic signed [63:0] w, hi, lo;
      w = 64'(v);
      hi = (64'sd1 <<< (COORD_BITS-1)) - 64'sd1;
      lo = -hi - 64'sd1;
      if (w > hi) return COORD_BITS'(hi);
      if (w < lo) return COORD_BITS'(lo);
      return COORD_BITS'(w);
   endfunction

   function automatic logic signed [VEC_BITS-1:0] fld(input logic [62:0] r, input int lo);
      return VEC_BITS'($signed(r[lo +: LINK_BITS]));
   endfunction

   assign s = $signed(trig_ff[j_ff*36 +: 18]);
   assign c = $signed(trig_ff[j_ff*36+18 +: 18]);
   assign base = (k_ff < 3'd3) ? 3'd0 : 3'd3;
   always_comb begin
      case (j_ff)
         3'd3: axis = AXIS_X;
         3'd0, 3'd5: axis = AXIS_Z;
         default: axis = AXIS_Y;
      endcase
      rx = vx_ff; ry = vy_ff; rz = vz_ff;
      case (axis)
         AXIS_X: begin
            ry = rnd(43'(c*vy_ff) - 43'(s*vz_ff));
            rz = rnd(43'(s*vy_ff) + 43'(c*vz_ff));
         end
         AXIS_Y: begin
            rx = rnd(43'(c*vx_ff) + 43'(s*vz_ff));
            rz = rnd(43'(c*vz_ff) - 43'(s*vx_ff));
         end
         default: begin
            rx = rnd(43'(c*vx_ff) - 43'(s*vy_ff));
            ry = rnd(43'(s*vx_ff) + 43'(c*vy_ff));
         end
      endcase
   end

   assign step_done = (j_ff == base);
   assign emit = busy_ff && step_done && (!ov_ff || out_ready);
   assign take = q_valid && q_ready;
   assign q_ready = !busy_ff || (emit && k_ff == 3'd5);
   assign sx = px_ff + SUM_BITS'(rx);
   assign sy = py_ff + SUM_BITS'(ry);
   assign sz = pz_ff + SUM_BITS'(rz);

   always_comb begin
      busy_in = busy_ff; k_in = k_ff; j_in = j_ff;
      vx_in = vx_ff; vy_in = vy_ff; vz_in = vz_ff;
      px_in = px_ff; py_in = py_ff; pz_in = pz_ff;
      ov_in = ov_ff && !out_ready;
      oj_in = oj_ff; ox_in = ox_ff; oy_in = oy_ff; oz_in = oz_ff;
      if (busy_ff && !step_done) begin
         j_in = j_ff - 3'd1;
         vx_in = rx; vy_in = ry; vz_in = rz;
      end else if (emit) begin
         ov_in = 1'b1; oj_in = k_ff;
         ox_in = sat(sx); oy_in = sat(sy); oz_in = sat(sz);
         px_in = sx; py_in = sy; pz_in = sz;
         if (k_ff == 3'd5) busy_in = 1'b0;
         else begin
            k_in = k_ff + 3'd1; j_in = k_ff + 3'd1;
            vx_in = fld(links[k_in*63 +: 63], 0);
            vy_in = fld(links[k_in*63 +: 63], 21);
            vz_in = fld(links[k_in*63 +: 63], 42);
         end
      end
      if (take) begin
         busy_in = 1'b1; k_in = 3'd0; j_in = 3'd0;
         px_in = '0; py_in = '0; pz_in = '0;
         vx_in = fld(links[62:0], 0);
         vy_in = fld(links[62:0], 21);
         vz_in = fld(links[62:0], 42);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         ov_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         ov_ff <= ov_in;
      end
      if (take) trig_ff <= q_trig;
      k_ff <= k_in; j_ff <= j_in;
      vx_ff <= vx_in; vy_ff <= vy_in; vz_ff <= vz_in;
      px_ff <= px_in; py_ff <= py_in; pz_ff <= pz_in;
      oj_ff <= oj_in; ox_ff <= ox_in; oy_ff <= oy_in; oz_ff <= oz_in;
   end

   assign out_valid = ov_ff;
   assign out_joint = oj_ff;
   assign out_x = ox_ff;
   assign out_y = oy_ff;
   assign out_z = oz_ff;
   assign out_last = (oj_ff == 3'd5);

`ifndef SYNTHESIS
   a_take: assert property (@(posedge clock) disable iff (reset) take |-> !busy_ff || emit)
      else $error("job taken while busy");
   a_j: assert property (@(posedge clock) disable iff (reset) busy_ff |-> j_ff <= k_ff)
      else $error("step index past joint");
   a_emit: assert property (@(posedge clock) disable iff (reset)
      (emit && k_ff != 3'd5) |=> busy_ff)
      else $error("job ended early");
`endif
endmodule

// File: hdl/arm_forward_kinematics.sv
// top level: six-joint arm forward kinematics
//  channel | direction | word
//  req     | in        | six joint angles
//  rsp     | out       | joint number, x/y/z position, last flag
//  csr     | in        | link vector write
// front end computes sine/cosine of all six angles in the square, inner, outer and final phases, one 16x16 multiply
// per lane per cycle, into a 2-deep queue.
// back end does one rotation per cycle except while a stall on rsp holds it, all through
// the single shared rotation unit; results leave through an output register.
// reset clears control and link registers; a stall on rsp holds the back end, and the
// front end keeps accepting until its queue and stage register fill.
module arm_forward_kinematics #(
   parameter int ANGLE_BITS = afk_pkg::ANGLE_BITS_DEF,
   parameter int COORD_BITS = afk_pkg::COORD_BITS_DEF
) (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_ready,
   input  logic [ANGLE_BITS-1:0] req_angle_one,
   input  logic [ANGLE_BITS-1:0] req_angle_two,
   input  logic [ANGLE_BITS-1:0] req_angle_three,
   input  logic [ANGLE_BITS-1:0] req_angle_four,
   input  logic [ANGLE_BITS-1:0] req_angle_five,
   input  logic [ANGLE_BITS-1:0] req_angle_six,
   output logic rsp_valid,
   input  logic rsp_ready,
   output logic [2:0] rsp_joint_number,
   output logic signed [COORD_BITS-1:0] rsp_pos_x,
   output logic signed [COORD_BITS-1:0] rsp_pos_y,
   output logic signed [COORD_BITS-1:0] rsp_pos_z,
   output logic rsp_last_joint,
   input  logic csr_write_enable,
   input  logic [afk_pkg::CSR_ADDR_BITS-1:0] csr_index,
   input  logic [afk_pkg::CSR_DATA_BITS-1:0] csr_write_data
);
   import afk_pkg::*;
   logic [62:0] link_ff [NUM_JOINTS];
   logic [6*63-1:0] links;
   logic q_valid, q_ready;
   logic [6*36-1:0] q_trig;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_JOINTS; i++) link_ff[i] <= '0;
      end else if (csr_write_enable && csr_index < 3'(NUM_JOINTS)) begin
         link_ff[csr_index] <= csr_write_data;
      end
   end
   always_comb begin
      for (int i = 0; i < NUM_JOINTS; i++) links[i*63 +: 63] = link_ff[i];
   end

   afk_front #(.ANGLE_BITS(ANGLE_BITS)) u_front (
      .clock, .reset,
      .in_valid(req_valid), .in_ready(req_ready),
      .in_angles({req_angle_six, req_angle_five, req_angle_four,
                  req_angle_three, req_angle_two, req_angle_one}),
      .q_valid, .q_ready, .q_trig
   );

   afk_back #(.COORD_BITS(COORD_BITS)) u_back (
      .clock, .reset, .q_valid, .q_ready, .q_trig, .links,
      .out_valid(rsp_valid), .out_ready(rsp_ready),
      .out_joint(rsp_joint_number), .out_x(rsp_pos_x), .out_y(rsp_pos_y),
      .out_z(rsp_pos_z), .out_last(rsp_last_joint)
   );
endmodule

// File: test/afk_tb_pkg.sv
// words carried on the request and response channels of the kinematics testbench
package afk_tb_pkg;
   localparam int ANGLE_W = afk_pkg::ANGLE_BITS_DEF;
   localparam int COORD_W = afk_pkg::COORD_BITS_DEF;

   typedef struct packed {
      logic [afk_pkg::NUM_JOINTS-1:0][ANGLE_W-1:0] angle;
   } angle_word_type;

   typedef struct packed {
      logic [2:0] joint_number;
      logic signed [COORD_W-1:0] pos_x;
      logic signed [COORD_W-1:0] pos_y;
      logic signed [COORD_W-1:0] pos_z;
      logic last_joint;
   } position_word_type;
endpackage

// File: test/afk_checker.sv
// checker: predicts the six joint end positions of each angle word and compares them
module afk_checker (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   input  logic req_ready,
   input  afk_tb_pkg::angle_word_type req_data,
   input  logic rsp_valid,
   input  logic rsp_ready,
   input  afk_tb_pkg::position_word_type rsp_data,
   input  logic csr_write_enable,
   input  logic [afk_pkg::CSR_ADDR_BITS-1:0] csr_index,
   input  logic [afk_pkg::CSR_DATA_BITS-1:0] csr_write_data,
   output int failures,
   output int pending
);
   import afk_pkg::*;
   import afk_tb_pkg::*;

   typedef struct {
      longint x;
      longint y;
      longint z;
   } vector_type;

   logic [CSR_DATA_BITS-1:0] link_shadow [NUM_JOINTS];
   position_word_type position_queue [$];
   int mismatches;

   function automatic longint poly_sine(longint f);
      longint x, x2, t;
      x = f * 2;
      x2 = (x * x) >>> 15;
      t = 21024 - ((x2 * 2320) >>> 15);
      t = 51472 - ((x2 * t) >>> 15);
      t = (x * t) >>> 15;
      return (t > 32767) ? 32767 : t;
   endfunction

   function automatic longint turn_sine(logic [15:0] a);
      longint f, m;
      f = longint'(a[13:0]);
      m = a[14] ? poly_sine(16384 - f) : poly_sine(f);
      return a[15] ? -m : m;
   endfunction

   function automatic longint round_q15(longint v);
      return (v + 16384) >>> 15;
   endfunction

   function automatic vector_type turn_vector(vector_type v, axis_type axis,
                                              logic [ANGLE_W-1:0] raw);
      logic [15:0] a;
      logic [23:0] wide;
      longint s, c;
      vector_type r;
      wide = 24'(raw) << (24 - ANGLE_W);
      a = wide[23:8];
      s = turn_sine(a);
      c = turn_sine(a + 16'd16384);
      r = v;
      case (axis)
         AXIS_X: begin
            r.y = round_q15(c * v.y - s * v.z);
            r.z = round_q15(s * v.y + c * v.z);
         end
         AXIS_Y: begin
            r.x = round_q15(c * v.x + s * v.z);
            r.z = round_q15(c * v.z - s * v.x);
         end
         default: begin
            r.x = round_q15(c * v.x - s * v.y);
            r.y = round_q15(s * v.x + c * v.y);
         end
      endcase
      return r;
   endfunction

   function automatic logic signed [COORD_W-1:0] clamp_coord(longint v);
      longint hi, lo;
      hi = (longint'(1) << (COORD_W - 1)) - 1;
      lo = -hi - 1;
      if (v > hi) v = hi;
      if (v < lo) v = lo;
      return v[COORD_W-1:0];
   endfunction

   task automatic predict_positions(angle_word_type w);
      vector_type p, v;
      position_word_type e;
      axis_type axis;
      int base;
      p = '{0, 0, 0};
      for (int k = 0; k < NUM_JOINTS; k++) begin
         v.x = longint'($signed(link_shadow[k][20:0]));
         v.y = longint'($signed(link_shadow[k][41:21]));
         v.z = longint'($signed(link_shadow[k][62:42]));
         base = (k < 3) ? 0 : 3;
         for (int j = k; j >= base; j--) begin
            axis = (j == 3) ? AXIS_X : ((j == 0 || j == 5) ? AXIS_Z : AXIS_Y);
            v = turn_vector(v, axis, w.angle[j]);
         end
         p.x += v.x;
         p.y += v.y;
         p.z += v.z;
         e.joint_number = 3'(k);
         e.pos_x = clamp_coord(p.x);
         e.pos_y = clamp_coord(p.y);
         e.pos_z = clamp_coord(p.z);
         e.last_joint = (k == NUM_JOINTS - 1);
         position_queue.push_back(e);
      end
   endtask

   task automatic flag_mismatch(string what, longint want, longint got);
      failures++;
      mismatches++;
      if (mismatches <= 10)
         $display("mismatch %s: expected %0d actual %0d", what, want, got);
   endtask

   assign pending = position_queue.size();

   initial begin
      failures = 0;
      mismatches = 0;
      for (int k = 0; k < NUM_JOINTS; k++) link_shadow[k] = '0;
   end

   always @(posedge clock) begin
      position_word_type e;
      if (reset) begin
         for (int k = 0; k < NUM_JOINTS; k++) link_shadow[k] <= '0;
      end else begin
         if (csr_write_enable && csr_index < NUM_JOINTS)
            link_shadow[csr_index] <= csr_write_data;
         if (req_valid && req_ready)
            predict_positions(req_data);
         if (rsp_valid && rsp_ready) begin
            if (position_queue.size() == 0) begin
               failures++;
               mismatches++;
               if (mismatches <= 10) $display("mismatch: unexpected position word");
            end else begin
               e = position_queue.pop_front();
               if (rsp_data.joint_number !== e.joint_number)
                  flag_mismatch("joint_number", e.joint_number, rsp_data.joint_number);
               if (rsp_data.pos_x !== e.pos_x) flag_mismatch("pos_x", e.pos_x, rsp_data.pos_x);
               if (rsp_data.pos_y !== e.pos_y) flag_mismatch("pos_y", e.pos_y, rsp_data.pos_y);
               if (rsp_data.pos_z !== e.pos_z) flag_mismatch("pos_z", e.pos_z, rsp_data.pos_z);
               if (rsp_data.last_joint !== e.last_joint)
                  flag_mismatch("last_joint", e.last_joint, rsp_data.last_joint);
            end
         end
      end
   end
endmodule

// File: test/arm_forward_kinematics_tb.sv
// testbench top: drives angle words and link writes into the kinematics block
module arm_forward_kinematics_tb;
   import afk_pkg::*;
   import afk_tb_pkg::*;

   localparam int WATCHDOG_LIMIT = 4000;
   localparam int DRAIN_CYCLES = 40;

   logic clock = 0;
   logic reset = 1;
   logic csr_write_enable = 0;
   logic [CSR_ADDR_BITS-1:0] csr_index = '0;
   logic [CSR_DATA_BITS-1:0] csr_write_data = '0;
   logic steady = 0;
   int failures, pending;
   int idle_cycles = 0;

   afk_if #(.payload_type(angle_word_type)) req_ch (clock);
   afk_if #(.payload_type(position_word_type)) rsp_ch (clock);

   initial begin
      req_ch.valid = 0;
      req_ch.data = '0;
      rsp_ch.ready = 0;
   end

   arm_forward_kinematics dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_ch.valid),
      .req_ready(req_ch.ready),
      .req_angle_one(req_ch.data.angle[0]),
      .req_angle_two(req_ch.data.angle[1]),
      .req_angle_three(req_ch.data.angle[2]),
      .req_angle_four(req_ch.data.angle[3]),
      .req_angle_five(req_ch.data.angle[4]),
      .req_angle_six(req_ch.data.angle[5]),
      .rsp_valid(rsp_ch.valid),
      .rsp_ready(rsp_ch.ready),
      .rsp_joint_number(rsp_ch.data.joint_number),
      .rsp_pos_x(rsp_ch.data.pos_x),
      .rsp_pos_y(rsp_ch.data.pos_y),
      .rsp_pos_z(rsp_ch.data.pos_z),
      .rsp_last_joint(rsp_ch.data.last_joint),
      .csr_write_enable(csr_write_enable),
      .csr_index(csr_index),
      .csr_write_data(csr_write_data)
   );

   afk_checker u_checker (
      .clock(clock),
      .reset(reset),
      .req_valid(req_ch.valid),
      .req_ready(req_ch.ready),
      .req_data(req_ch.data),
      .rsp_valid(rsp_ch.valid),
      .rsp_ready(rsp_ch.ready),
      .rsp_data(rsp_ch.data),
      .csr_write_enable(csr_write_enable),
      .csr_index(csr_index),
      .csr_write_data(csr_write_data),
      .failures(failures),
      .pending(pending)
   );

   always #6 clock = ~clock;

   function automatic int gap_length();
      int r;
      r = $urandom_range(0, 99);
      if (steady || r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // response side stalls
   always @(posedge clock) begin
      int stall;
      if (!reset) begin
         stall = gap_length();
         if (stall > 0) begin
            rsp_ch.ready <= 0;
            repeat (stall) @(posedge clock);
         end
         rsp_ch.ready <= 1;
      end
   end

   always @(posedge clock) begin
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) || csr_write_enable)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("FAIL arm_forward_kinematics");
         $finish;
      end
   end

   function automatic logic [ANGLE_W-1:0] pick_angle();
      logic [ANGLE_W-1:0] corners [7] = '{16'h0000, 16'h3fff, 16'h4000, 16'h8000,
                                         16'hc000, 16'hffff, 16'h7fff};
      if ($urandom_range(0, 9) == 0) return corners[$urandom_range(0, 6)];
      return ANGLE_W'($urandom);
   endfunction

   function automatic logic [CSR_DATA_BITS-1:0] link_pack(logic [20:0] x, logic [20:0] y,
                                                         logic [20:0] z);
      return {z, y, x};
   endfunction

   function automatic logic [20:0] pick_field(int style);
      case (style)
         1: return 21'h0fffff;
         2: return 21'h100000;
         3: return 21'($urandom_range(0, 4000)) - 21'd2000;
         default: return 21'($urandom);
      endcase
   endfunction

   task automatic send_word(angle_word_type w);
      int gap;
      gap = gap_length();
      if (gap > 0) begin
         req_ch.valid <= 0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid <= 1;
      req_ch.data <= w;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
   endtask

   task automatic wait_idle();
      req_ch.valid <= 0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_links(int style);
      for (int k = 0; k < 8; k++) begin
         csr_write_enable <= 1;
         csr_index <= CSR_ADDR_BITS'(k);
         if (k >= NUM_JOINTS)
            csr_write_data <= CSR_DATA_BITS'({$urandom, $urandom});
         else if (style == 0)
            csr_write_data <= CSR_DATA_BITS'({$urandom, $urandom});
         else
            csr_write_data <= link_pack(pick_field(style), pick_field(style),
                                        pick_field(style));
         @(posedge clock);
      end
      csr_write_enable <= 0;
      @(posedge clock);
   endtask

   initial begin
      angle_word_type w;
      logic [ANGLE_W-1:0] edge_angles [6];
      edge_angles = '{16'h0000, 16'hffff, 16'h4000, 16'h8000, 16'hc000, 16'h2000};
      repeat (4) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // zero links straight after reset
      for (int i = 0; i < 3; i++) begin
         for (int j = 0; j < NUM_JOINTS; j++) w.angle[j] = pick_angle();
         send_word(w);
      end
      wait_idle();

      // directed: corner angles on small links, then full scale
      write_links(3);
      for (int i = 0; i < 12; i++) begin
         for (int j = 0; j < NUM_JOINTS; j++) w.angle[j] = edge_angles[(i + j) % 6];
         if (i >= 6) w.angle = {NUM_JOINTS{edge_angles[i % 6]}};
         send_word(w);
      end
      wait_idle();
      write_links(1);
      for (int i = 0; i < 5; i++) begin
         w.angle = {NUM_JOINTS{edge_angles[i]}};
         send_word(w);
      end
      wait_idle();
      write_links(2);
      for (int i = 0; i < 5; i++) begin
         w.angle = {NUM_JOINTS{edge_angles[i]}};
         send_word(w);
      end
      wait_idle();

      // random phases with different link settings
      for (int phase = 0; phase < 8; phase++) begin
         write_links(phase % 4);
         steady = (phase == 3 || phase == 6);
         for (int i = 0; i < 40; i++) begin
            for (int j = 0; j < NUM_JOINTS; j++) w.angle[j] = pick_angle();
            send_word(w);
         end
         wait_idle();
      end

      if (failures == 0)
         $display("PASS arm_forward_kinematics");
      else
         $display("FAIL arm_forward_kinematics");
      $finish;
   end
endmodule

// File: files.f
hdl/afk_pkg.sv
hdl/afk_if.sv
hdl/afk_front.sv
hdl/afk_back.sv
hdl/arm_forward_kinematics.sv
test/afk_tb_pkg.sv
test/afk_checker.sv
test/arm_forward_kinematics_tb.sv
